[rtl/core/assert_macros.svh]
// Assertion macros shared by the adjacent hit run core.
// Users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge out of reset.
`define AHRTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never true out of reset.
`define AHRTD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/ahrtd_pkg.sv]
// Package for the adjacent hit run time difference core.
// Sizes, codes, control structs and the run qualification function; no dependencies.
package ahrtd_pkg;

    localparam int PLANE_COUNT        = 5;
    localparam int PADDLE_COUNT       = 11;
    localparam int MAX_HITS_PER_PLANE = 100;

    localparam int PLANE_W   = 3;
    localparam int PADDLE_W  = 8;
    localparam int TIME_W    = 24;
    localparam int DIFF_W    = 25;
    localparam int BIN_W     = 8;
    localparam int PAIR_W    = 4;
    localparam int RUN_W     = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam int PLANE_IDX_W = $clog2(PLANE_COUNT);
    localparam int PAD_IDX_W   = $clog2(PADDLE_COUNT);
    localparam int PAIR_COUNT  = PADDLE_COUNT - 1;
    localparam int STEP_W      = $clog2(PAIR_COUNT);
    localparam int HIT_CNT_W   = $clog2(MAX_HITS_PER_PLANE + 1);

    localparam logic [RUN_W-1:0] RUN_LEN_RESET = 4'd5;

    localparam logic REQ_HIT = 1'b0;
    localparam logic REQ_EOE = 1'b1;

    // bin = 1 + floor((d + 768) * 25 / 192); /192 = >>6 then /3 by reciprocal
    localparam int RANGE_UNITS = 768;
    localparam logic signed [DIFF_W-1:0] RANGE_NEG = DIFF_W'(-RANGE_UNITS);
    localparam logic signed [DIFF_W-1:0] RANGE_POS = DIFF_W'(RANGE_UNITS);
    localparam int BIN_X_W     = 11;
    localparam int BIN_MUL     = 25;
    localparam int BIN_P_W     = 16;
    localparam int BIN_SHIFT   = 6;
    localparam int BIN_Y_W     = 10;
    localparam int DIV3_MUL    = 683;
    localparam int DIV3_P_W    = 20;
    localparam int DIV3_SHIFT  = 11;
    localparam logic [BIN_W-1:0] BIN_UNDER = 8'd0;
    localparam logic [BIN_W-1:0] BIN_OVER  = 8'd201;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SHIFT
    } scan_st_t;

    typedef struct packed {
        logic                   wr_en;
        logic [PLANE_IDX_W-1:0] wr_plane;
        logic [PAD_IDX_W-1:0]   wr_paddle;
        logic [TIME_W-1:0]      wr_time;
        logic                   load;
        logic                   shift;
        logic                   clear;
        logic [PLANE_IDX_W-1:0] scan_plane;
    } cell_ctl_t;

    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [PAIR_W-1:0]  idx;
        logic [TIME_W-1:0]  t_lo;
        logic [TIME_W-1:0]  t_hi;
        logic               last;
    } pair_t;

    // Bit j set when pair (j, j+1) lies in a run of at least max(min_len, 2) hits.
    function automatic logic [PAIR_COUNT-1:0] pair_qual(
        input logic [PADDLE_COUNT-1:0] m,
        input logic [RUN_W-1:0]        min_len
    );
        logic [PADDLE_COUNT-1:0] win;
        logic [PAIR_COUNT-1:0]   q;
        int                      len;
        len = (min_len < RUN_W'(2)) ? 2 : int'(min_len);
        for (int s = 0; s < PADDLE_COUNT; s++)
        begin
            win[s] = 1'b1;
            for (int i = 0; i < (1 << RUN_W); i++)
            begin
                if (i < len)
                begin
                    if (s + i >= PADDLE_COUNT)
                        win[s] = 1'b0;
                    else if (!m[s + i])
                        win[s] = 1'b0;
                end
            end
        end
        for (int j = 0; j < PAIR_COUNT; j++)
        begin
            q[j] = 1'b0;
            for (int s = 0; s < PADDLE_COUNT; s++)
            begin
                if (s <= j && j + 1 <= s + len - 1)
                    q[j] = q[j] | win[s];
            end
        end
        return q;
    endfunction

endpackage

[rtl/core/adjacent_hit_run_time_diff_core.sv]
// Channel   | Dir | Handshake            | Payload
// cfg       | in  | cfg_valid/cfg_ready  | cfg_data: min_run_length
// s (hits)  | in  | s_tvalid/s_tready    | s_tdata: plane, paddle, time; s_tuser: req_type
// m (pairs) | out | m_tvalid/m_tready    | m_tdata: plane, pair, diff, bin; m_tlast
// Hit items are accepted while idle. End of event scans every plane through the paddle cell chain:
// per plane a load step, then one shift per adjacent pair, stalling while the output
// is not ready for a qualifying pair; s_tready is low during the scan.
// Results pass a two-stage output pipeline (difference, then bin); cfg_ready is always high.
// Reset clears presence bits and hit counts and sets min_run_length to 5; stored times need no reset.
// Depends on ahrtd_pkg, ahrtd_cell, ahrtd_emit and assert_macros.svh.
`include "assert_macros.svh"

module adjacent_hit_run_time_diff_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ahrtd_pkg::RUN_W-1:0]          cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ahrtd_pkg::IN_DATA_W-1:0]      s_tdata,  // plane, paddle_number, hit_time
    input  logic                                 s_tuser,  // req_type
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ahrtd_pkg::OUT_DATA_W-1:0]     m_tdata,  // out_plane, pair_index, time_difference, bin_index
    output logic                                 m_tlast   // last_of_event
);

    localparam int PLC = ahrtd_pkg::PLANE_COUNT;
    localparam int PDC = ahrtd_pkg::PADDLE_COUNT;

    ahrtd_pkg::scan_st_t                   state_reg;
    ahrtd_pkg::scan_st_t                   state_next;
    logic [ahrtd_pkg::RUN_W-1:0]           run_len_reg;
    logic [ahrtd_pkg::HIT_CNT_W-1:0]       hits_seen_reg [PLC];
    logic [ahrtd_pkg::PLANE_IDX_W-1:0]     plane_reg;
    logic [ahrtd_pkg::STEP_W-1:0]          step_reg;
    logic [ahrtd_pkg::PAIR_COUNT-1:0]      qual_reg;
    logic [PLC-1:0]                        plane_has_reg;

    logic [ahrtd_pkg::PLANE_W-1:0]         in_plane;
    logic [ahrtd_pkg::PADDLE_W-1:0]        in_paddle;
    logic [ahrtd_pkg::TIME_W-1:0]          in_time;
    logic                                  in_acc;
    logic                                  hit_acc;
    logic                                  eoe_acc;
    logic                                  plane_ok;
    logic                                  cnt_ok;
    logic                                  paddle_ok;
    logic                                  hit_count;

    ahrtd_pkg::cell_ctl_t                  ctl;
    logic [PLC-1:0]                        cell_present [PDC];
    logic [ahrtd_pkg::TIME_W-1:0]          cell_time [PDC];
    logic [PDC-1:0]                        plane_mask [PLC];
    logic                                  any_present;
    logic                                  hits_over;

    logic                                  adv;
    logic                                  step_last;
    logic                                  plane_last;
    logic                                  later_any;
    logic                                  pair_valid;
    logic                                  pair_ready;
    ahrtd_pkg::pair_t                      pair;

    assign in_plane  = s_tdata[ahrtd_pkg::PLANE_W-1:0];
    assign in_paddle = s_tdata[ahrtd_pkg::PLANE_W +: ahrtd_pkg::PADDLE_W];
    assign in_time   = s_tdata[ahrtd_pkg::PLANE_W + ahrtd_pkg::PADDLE_W +: ahrtd_pkg::TIME_W];

    assign in_acc    = s_tvalid && s_tready;
    assign hit_acc   = in_acc && (s_tuser == ahrtd_pkg::REQ_HIT);
    assign eoe_acc   = in_acc && (s_tuser == ahrtd_pkg::REQ_EOE);
    assign plane_ok  = in_plane < ahrtd_pkg::PLANE_W'(PLC);
    assign cnt_ok    = hits_seen_reg[in_plane[ahrtd_pkg::PLANE_IDX_W-1:0]]
                     < ahrtd_pkg::HIT_CNT_W'(ahrtd_pkg::MAX_HITS_PER_PLANE);
    assign paddle_ok = (in_paddle != '0) && (in_paddle <= ahrtd_pkg::PADDLE_W'(PDC));
    assign hit_count = hit_acc && plane_ok && cnt_ok;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int p = 0; p < PLC; p++)
        begin
            for (int k = 0; k < PDC; k++)
                plane_mask[p][k] = cell_present[k][p];
        end
        any_present = 1'b0;
        hits_over   = 1'b0;
        later_any   = 1'b0;
        for (int p = 0; p < PLC; p++)
        begin
            any_present = any_present | (|plane_mask[p]);
            hits_over   = hits_over
                        | (hits_seen_reg[p] > ahrtd_pkg::HIT_CNT_W'(ahrtd_pkg::MAX_HITS_PER_PLANE));
            if (ahrtd_pkg::PLANE_IDX_W'(p) > plane_reg)
                later_any = later_any | plane_has_reg[p];
        end
    end

    assign step_last  = step_reg == ahrtd_pkg::STEP_W'(ahrtd_pkg::PAIR_COUNT - 1);
    assign plane_last = plane_reg == ahrtd_pkg::PLANE_IDX_W'(PLC - 1);
    assign adv        = !qual_reg[0] || pair_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ahrtd_pkg::ST_IDLE:
            begin
                if (eoe_acc)
                    state_next = ahrtd_pkg::ST_LOAD;
            end
            ahrtd_pkg::ST_LOAD:
                state_next = ahrtd_pkg::ST_SHIFT;
            ahrtd_pkg::ST_SHIFT:
            begin
                if (adv && step_last)
                    state_next = plane_last ? ahrtd_pkg::ST_IDLE : ahrtd_pkg::ST_LOAD;
            end
            default:
                state_next = ahrtd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready       = 1'b0;
        pair_valid     = 1'b0;
        ctl.wr_en      = hit_count && paddle_ok;
        ctl.wr_plane   = in_plane[ahrtd_pkg::PLANE_IDX_W-1:0];
        ctl.wr_paddle  = ahrtd_pkg::PAD_IDX_W'(in_paddle - ahrtd_pkg::PADDLE_W'(1));
        ctl.wr_time    = in_time;
        ctl.load       = 1'b0;
        ctl.shift      = 1'b0;
        ctl.clear      = 1'b0;
        ctl.scan_plane = plane_reg;
        unique case (state_reg)
            ahrtd_pkg::ST_IDLE:
                s_tready = 1'b1;
            ahrtd_pkg::ST_LOAD:
                ctl.load = 1'b1;
            ahrtd_pkg::ST_SHIFT:
            begin
                pair_valid = qual_reg[0];
                ctl.shift  = adv;
                ctl.clear  = adv && step_last && plane_last;
            end
            default:
                s_tready = 1'b0;
        endcase
    end

    assign pair.plane = ahrtd_pkg::PLANE_W'(plane_reg);
    assign pair.idx   = ahrtd_pkg::PAIR_W'(step_reg);
    assign pair.t_lo  = cell_time[0];
    assign pair.t_hi  = cell_time[1];
    assign pair.last  = ((qual_reg >> 1) == '0) && !later_any;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ahrtd_pkg::ST_IDLE;
            run_len_reg   <= ahrtd_pkg::RUN_LEN_RESET;
            plane_reg     <= '0;
            step_reg      <= '0;
            qual_reg      <= '0;
            plane_has_reg <= '0;
            for (int p = 0; p < PLC; p++)
                hits_seen_reg[p] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                run_len_reg <= cfg_data;
            if (eoe_acc)
            begin
                plane_reg <= '0;
                for (int p = 0; p < PLC; p++)
                    plane_has_reg[p] <= |ahrtd_pkg::pair_qual(plane_mask[p], run_len_reg);
            end
            if (ctl.load)
            begin
                step_reg <= '0;
                qual_reg <= ahrtd_pkg::pair_qual(plane_mask[plane_reg], run_len_reg);
            end
            else if (ctl.shift)
            begin
                step_reg <= step_reg + ahrtd_pkg::STEP_W'(1);
                qual_reg <= qual_reg >> 1;
                if (step_last && !plane_last)
                    plane_reg <= plane_reg + ahrtd_pkg::PLANE_IDX_W'(1);
            end
            if (ctl.clear)
            begin
                for (int p = 0; p < PLC; p++)
                    hits_seen_reg[p] <= '0;
            end
            else if (hit_count)
                hits_seen_reg[in_plane[ahrtd_pkg::PLANE_IDX_W-1:0]] <=
                    hits_seen_reg[in_plane[ahrtd_pkg::PLANE_IDX_W-1:0]] + ahrtd_pkg::HIT_CNT_W'(1);
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < PDC; gk++)
        begin : g_cell
            logic [ahrtd_pkg::TIME_W-1:0] shift_in;
            if (gk == PDC - 1)
            begin : g_tail
                assign shift_in = '0;
            end
            else
            begin : g_link
                assign shift_in = cell_time[gk + 1];
            end

            ahrtd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .cell_index (ahrtd_pkg::PAD_IDX_W'(gk)),
                .shift_in   (shift_in),
                .present    (cell_present[gk]),
                .shift_out  (cell_time[gk])
            );
        end
    endgenerate

    ahrtd_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair       (pair),
        .pair_ready (pair_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    `AHRTD_ASSERT(a_store_cleared, ctl.clear |=> !any_present, "store not cleared after scan")
    `AHRTD_ASSERT(a_no_pending_pair, ctl.clear |-> ((qual_reg >> 1) == '0), "scan ended with pairs left")
    `AHRTD_ASSERT_NEVER(a_hit_cap, hits_over, "hit count above per-plane limit")

endmodule

[rtl/core/ahrtd_cell.sv]
// One paddle cell: per-plane presence bit and first-hit time, plus a scan shift stage.
// Depends on ahrtd_pkg.
module ahrtd_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ahrtd_pkg::cell_ctl_t                ctl,
    input  logic [ahrtd_pkg::PAD_IDX_W-1:0]     cell_index,
    input  logic [ahrtd_pkg::TIME_W-1:0]        shift_in,
    output logic [ahrtd_pkg::PLANE_COUNT-1:0]   present,
    output logic [ahrtd_pkg::TIME_W-1:0]        shift_out
);

    logic [ahrtd_pkg::PLANE_COUNT-1:0] present_reg;
    logic [ahrtd_pkg::PLANE_COUNT-1:0] present_next;
    logic [ahrtd_pkg::TIME_W-1:0]      time_reg [ahrtd_pkg::PLANE_COUNT];
    logic [ahrtd_pkg::TIME_W-1:0]      shift_reg;
    logic                              hit_wr;

    assign hit_wr = ctl.wr_en && (ctl.wr_paddle == cell_index) && !present_reg[ctl.wr_plane];

    always_comb
    begin
        present_next = present_reg;
        if (ctl.clear)
            present_next = '0;
        else if (hit_wr)
            present_next[ctl.wr_plane] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            present_reg <= '0;
        else
            present_reg <= present_next;
    end

    always_ff @(posedge clk)
    begin
        if (hit_wr)
            time_reg[ctl.wr_plane] <= ctl.wr_time;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            shift_reg <= time_reg[ctl.scan_plane];
        else if (ctl.shift)
            shift_reg <= shift_in;
    end

    assign present   = present_reg;
    assign shift_out = shift_reg;

endmodule

[rtl/core/ahrtd_emit.sv]
// Result pipeline: time difference and bin preparation, then bin and output register.
// Depends on ahrtd_pkg.
module ahrtd_emit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pair_valid,
    input  ahrtd_pkg::pair_t                     pair,
    output logic                                 pair_ready,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ahrtd_pkg::OUT_DATA_W-1:0]     m_tdata,  // out_plane, pair_index, time_difference, bin_index
    output logic                                 m_tlast   // last_of_event
);

    logic                                  mid_valid_reg;
    logic [ahrtd_pkg::PLANE_W-1:0]         mid_plane_reg;
    logic [ahrtd_pkg::PAIR_W-1:0]          mid_idx_reg;
    logic signed [ahrtd_pkg::DIFF_W-1:0]   mid_diff_reg;
    logic [ahrtd_pkg::BIN_Y_W-1:0]         mid_y_reg;
    logic                                  mid_under_reg;
    logic                                  mid_over_reg;
    logic                                  mid_last_reg;

    logic                                  out_valid_reg;
    logic [ahrtd_pkg::PLANE_W-1:0]         out_plane_reg;
    logic [ahrtd_pkg::PAIR_W-1:0]          out_idx_reg;
    logic [ahrtd_pkg::DIFF_W-1:0]          out_diff_reg;
    logic [ahrtd_pkg::BIN_W-1:0]           out_bin_reg;
    logic                                  out_last_reg;

    logic                                  out_free;
    logic                                  mid_free;
    logic signed [ahrtd_pkg::DIFF_W-1:0]   diff;
    logic [ahrtd_pkg::DIFF_W-1:0]          x_full;
    logic [ahrtd_pkg::BIN_P_W-1:0]         x_prod;
    logic [ahrtd_pkg::DIV3_P_W-1:0]        q_prod;
    logic [ahrtd_pkg::BIN_W-1:0]           bin;

    assign out_free   = !out_valid_reg || m_tready;
    assign mid_free   = !mid_valid_reg || out_free;
    assign pair_ready = mid_free;

    always_comb
    begin
        diff   = $signed({pair.t_hi[ahrtd_pkg::TIME_W-1], pair.t_hi})
               - $signed({pair.t_lo[ahrtd_pkg::TIME_W-1], pair.t_lo});
        x_full = diff + ahrtd_pkg::RANGE_POS;
        x_prod = ahrtd_pkg::BIN_P_W'(x_full[ahrtd_pkg::BIN_X_W-1:0])
               * ahrtd_pkg::BIN_P_W'(ahrtd_pkg::BIN_MUL);
    end

    always_comb
    begin
        q_prod = ahrtd_pkg::DIV3_P_W'(mid_y_reg) * ahrtd_pkg::DIV3_P_W'(ahrtd_pkg::DIV3_MUL);
        priority if (mid_under_reg)
            bin = ahrtd_pkg::BIN_UNDER;
        else if (mid_over_reg)
            bin = ahrtd_pkg::BIN_OVER;
        else
            bin = q_prod[ahrtd_pkg::DIV3_SHIFT +: ahrtd_pkg::BIN_W] + ahrtd_pkg::BIN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mid_free)
                mid_valid_reg <= pair_valid;
            if (out_free)
                out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_free && pair_valid)
        begin
            mid_plane_reg <= pair.plane;
            mid_idx_reg   <= pair.idx;
            mid_diff_reg  <= diff;
            mid_y_reg     <= x_prod[ahrtd_pkg::BIN_SHIFT +: ahrtd_pkg::BIN_Y_W];
            mid_under_reg <= diff < ahrtd_pkg::RANGE_NEG;
            mid_over_reg  <= diff >= ahrtd_pkg::RANGE_POS;
            mid_last_reg  <= pair.last;
        end
        if (out_free && mid_valid_reg)
        begin
            out_plane_reg <= mid_plane_reg;
            out_idx_reg   <= mid_idx_reg;
            out_diff_reg  <= mid_diff_reg;
            out_bin_reg   <= bin;
            out_last_reg  <= mid_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bin_reg, out_diff_reg, out_idx_reg, out_plane_reg};
    assign m_tlast  = out_last_reg;

endmodule
